// File: src/wtoi_pkg.sv
package wtoi_pkg;

    // Default number of phase bits that address the wave table.
    localparam int TABLE_BITS_DEFAULT = 9;

    // Field widths of the transfer payloads.
    localparam int FUNC_W        = 2;
    localparam int FREQ_W        = 24;
    localparam int PHASE_W       = 32;
    localparam int ENTRY_INDEX_W = 9;
    localparam int VALUE_W       = 16;
    localparam int SLOPE_W       = 17;
    localparam int FRAC_W        = 16;

    // Configuration register file.
    localparam int MODE_W       = 2;
    localparam int INCR_SCALE_W = 24;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE       = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INCR_SCALE = 1'd1;

    localparam logic [MODE_W-1:0]       MODE_RESET       = 2'd0;
    localparam logic [INCR_SCALE_W-1:0] INCR_SCALE_RESET = 24'd97391;

    // Oscillator modes. The unused code behaves as frequency only.
    localparam logic [MODE_W-1:0] MODE_FREQ       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PHASE_ONLY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREQ_PHASE = 2'd2;

    // Input item functions. The unused code is dropped without a result.
    localparam logic [FUNC_W-1:0] FUNC_PROCESS   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_PHASE = 2'd2;

    // Output saturation limits.
    localparam logic signed [VALUE_W+2:0] SAMPLE_MAX = 19'sd32767;
    localparam logic signed [VALUE_W+2:0] SAMPLE_MIN = -19'sd32768;

    // One wave table entry.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [SLOPE_W-1:0] slope;
    } entry_t;

endpackage

// File: src/wtoi_table.sv
module wtoi_table #(
    parameter int TABLE_BITS = wtoi_pkg::TABLE_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [TABLE_BITS-1:0]  wr_addr,
    input  wtoi_pkg::entry_t       wr_data,
    input  logic                   rd_en,
    input  logic [TABLE_BITS-1:0]  rd_addr,
    output wtoi_pkg::entry_t       rd_data
);

    wtoi_pkg::entry_t mem [(1 << TABLE_BITS)];
    wtoi_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/wtoi_interp.sv
module wtoi_interp (
    input  logic [wtoi_pkg::FRAC_W-1:0]         frac,
    input  wtoi_pkg::entry_t                    entry,
    output logic signed [wtoi_pkg::VALUE_W-1:0] sample
);

    logic signed [wtoi_pkg::FRAC_W:0]                    frac_s;
    logic signed [wtoi_pkg::FRAC_W+wtoi_pkg::SLOPE_W:0]  prod;
    logic signed [wtoi_pkg::SLOPE_W:0]                   scaled;
    logic signed [wtoi_pkg::VALUE_W+2:0]                 sum;

    // The product floored by 2^16 is an arithmetic shift of the signed product.
    always_comb begin
        frac_s = $signed({1'b0, frac});
        prod   = frac_s * entry.slope;
        scaled = $signed(prod[wtoi_pkg::FRAC_W+wtoi_pkg::SLOPE_W:wtoi_pkg::FRAC_W]);
        sum    = (wtoi_pkg::VALUE_W+3)'(entry.value) + (wtoi_pkg::VALUE_W+3)'(scaled);
        if (sum > wtoi_pkg::SAMPLE_MAX) begin
            sample = wtoi_pkg::SAMPLE_MAX[wtoi_pkg::VALUE_W-1:0];
        end else if (sum < wtoi_pkg::SAMPLE_MIN) begin
            sample = wtoi_pkg::SAMPLE_MIN[wtoi_pkg::VALUE_W-1:0];
        end else begin
            sample = sum[wtoi_pkg::VALUE_W-1:0];
        end
    end

endmodule

// File: src/wavetable_oscillator_interp_top.sv
// Wavetable oscillator with linear interpolation between table entries.
// Input items arrive on the s_ channel and results leave on the m_ channel;
// both use a valid/ready handshake and a transfer happens when both are high.
// An item with s_func set to process yields exactly one m_sample_out; a table
// load, a set-phase item or the unused function code yields nothing.
// Configuration (mode, increment scale) is written through cfg_we, cfg_index
// and cfg_data with no wait. The user must write it only while the block
// holds no item; the block does not enforce this. The datapath has four
// register stages: input, phase step, table read and output. One item per
// cycle is sustained while the receiver does not stall: the running phase is
// the only value fed back, updated by a single add in the table-read stage.
// Each stage holds its item until the next stage has room, so when the
// receiver stalls the stages fill one by one and s_ready drops only when all
// four are occupied. Empty stages keep taking new items meanwhile.
// Reset clears the stage valid flags, the running phase and the registers to
// their defaults. Table contents are not cleared and must be loaded before use.
module wavetable_oscillator_interp_top #(
    parameter int TABLE_BITS = wtoi_pkg::TABLE_BITS_DEFAULT
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,

    input  logic                                        cfg_we,
    input  logic [wtoi_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [wtoi_pkg::CFG_DATA_W-1:0]             cfg_data,

    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic [wtoi_pkg::FUNC_W-1:0]                 s_func,
    input  logic signed [wtoi_pkg::FREQ_W-1:0]          s_freq_sample,
    input  logic [wtoi_pkg::PHASE_W-1:0]                s_phase_sample,
    input  logic [wtoi_pkg::ENTRY_INDEX_W-1:0]          s_entry_index,
    input  logic signed [wtoi_pkg::VALUE_W-1:0]         s_entry_value,
    input  logic signed [wtoi_pkg::SLOPE_W-1:0]         s_entry_slope,

    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [wtoi_pkg::VALUE_W-1:0]         m_sample_out
);

    localparam int IdxExtW = (TABLE_BITS > wtoi_pkg::ENTRY_INDEX_W) ?
                             TABLE_BITS : wtoi_pkg::ENTRY_INDEX_W;

    // Configuration registers.
    logic [wtoi_pkg::MODE_W-1:0]       mode_reg;
    logic [wtoi_pkg::INCR_SCALE_W-1:0] incr_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= wtoi_pkg::MODE_RESET;
            incr_scale_reg <= wtoi_pkg::INCR_SCALE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                wtoi_pkg::CFG_MODE: begin
                    mode_reg <= cfg_data[wtoi_pkg::MODE_W-1:0];
                end
                wtoi_pkg::CFG_INCR_SCALE: begin
                    incr_scale_reg <= cfg_data[wtoi_pkg::INCR_SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage handshakes: a stage loads when it is empty or its item moves on.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic out_ready, s3_ready, s2_ready, s1_ready;
    logic s2_fire;

    assign out_ready = !m_valid_reg || m_ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_ready   = s1_ready;
    assign s2_fire   = s2_valid_reg && s3_ready;

    // Stage 1: input register.
    logic [wtoi_pkg::FUNC_W-1:0]         s1_func_reg;
    logic signed [wtoi_pkg::FREQ_W-1:0]  s1_freq_reg;
    logic [wtoi_pkg::PHASE_W-1:0]        s1_phase_reg;
    logic [TABLE_BITS-1:0]               s1_addr_reg;
    wtoi_pkg::entry_t                    s1_entry_reg;
    logic [IdxExtW-1:0]                  idx_ext;

    assign idx_ext = IdxExtW'(s_entry_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && s_valid) begin
            s1_func_reg        <= s_func;
            s1_freq_reg        <= s_freq_sample;
            s1_phase_reg       <= s_phase_sample;
            s1_addr_reg        <= idx_ext[TABLE_BITS-1:0];
            s1_entry_reg.value <= s_entry_value;
            s1_entry_reg.slope <= s_entry_slope;
        end
    end

    // Stage 2: phase step. The signed product floored by 2^16 is the
    // arithmetic shift, and its low 32 bits give the step modulo a full turn.
    logic signed [wtoi_pkg::INCR_SCALE_W:0]                        incr_s;
    logic signed [wtoi_pkg::FREQ_W+wtoi_pkg::INCR_SCALE_W:0]       step_prod;
    logic [wtoi_pkg::PHASE_W-1:0]                                  step;

    assign incr_s    = $signed({1'b0, incr_scale_reg});
    assign step_prod = s1_freq_reg * incr_s;
    assign step      = step_prod[wtoi_pkg::PHASE_W+15:16];

    logic [wtoi_pkg::FUNC_W-1:0]   s2_func_reg;
    logic [wtoi_pkg::PHASE_W-1:0]  s2_phase_reg;
    logic [wtoi_pkg::PHASE_W-1:0]  s2_step_reg;
    logic [TABLE_BITS-1:0]         s2_addr_reg;
    wtoi_pkg::entry_t              s2_entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_func_reg  <= s1_func_reg;
            s2_phase_reg <= s1_phase_reg;
            s2_step_reg  <= step;
            s2_addr_reg  <= s1_addr_reg;
            s2_entry_reg <= s1_entry_reg;
        end
    end

    // Stage 3: running phase update and table access. Items leave this stage
    // in order, so a load always lands before any later read of its entry.
    logic [wtoi_pkg::PHASE_W-1:0] running_phase_reg;
    logic [wtoi_pkg::PHASE_W-1:0] running_phase_next;
    logic [wtoi_pkg::PHASE_W-1:0] read_phase;
    logic                         is_process;
    logic                         tbl_we;
    logic                         tbl_re;
    wtoi_pkg::entry_t             tbl_rd_data;

    assign is_process = (s2_func_reg == wtoi_pkg::FUNC_PROCESS);
    assign tbl_we     = s2_fire && (s2_func_reg == wtoi_pkg::FUNC_LOAD);
    assign tbl_re     = s2_fire && is_process;

    always_comb begin
        read_phase         = running_phase_reg;
        running_phase_next = running_phase_reg;
        case (s2_func_reg)
            wtoi_pkg::FUNC_PROCESS: begin
                case (mode_reg)
                    wtoi_pkg::MODE_PHASE_ONLY: begin
                        read_phase = s2_phase_reg;
                    end
                    wtoi_pkg::MODE_FREQ_PHASE: begin
                        read_phase         = running_phase_reg + s2_phase_reg;
                        running_phase_next = running_phase_reg + s2_step_reg;
                    end
                    default: begin
                        running_phase_next = running_phase_reg + s2_step_reg;
                    end
                endcase
            end
            wtoi_pkg::FUNC_SET_PHASE: begin
                running_phase_next = s2_phase_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_phase_reg <= '0;
        end else if (s2_fire) begin
            running_phase_reg <= running_phase_next;
        end
    end

    wtoi_table #(
        .TABLE_BITS (TABLE_BITS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (s2_addr_reg),
        .wr_data (s2_entry_reg),
        .rd_en   (tbl_re),
        .rd_addr (read_phase[wtoi_pkg::PHASE_W-1 -: TABLE_BITS]),
        .rd_data (tbl_rd_data)
    );

    // The fraction is the 16 phase bits right below the table index.
    logic [wtoi_pkg::FRAC_W-1:0] s3_frac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg && is_process;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_re) begin
            s3_frac_reg <= read_phase[wtoi_pkg::PHASE_W-1-TABLE_BITS -: wtoi_pkg::FRAC_W];
        end
    end

    // Stage 4: interpolation, saturation and the output register.
    logic signed [wtoi_pkg::VALUE_W-1:0] interp_sample;
    logic signed [wtoi_pkg::VALUE_W-1:0] m_sample_reg;

    wtoi_interp u_interp (
        .frac   (s3_frac_reg),
        .entry  (tbl_rd_data),
        .sample (interp_sample)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s3_valid_reg) begin
            m_sample_reg <= interp_sample;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

    // The input stalls only when every stage holds an item.
    a_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && m_valid_reg))
        else $error("input stalled with an empty stage");

    // The running phase moves only when an item leaves the table-read stage.
    a_phase_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s2_fire |=> $stable(running_phase_reg))
        else $error("running phase changed without an item");

    // In the waveshaper mode a process item never disturbs the running phase.
    a_shaper_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_fire && is_process && (mode_reg == wtoi_pkg::MODE_PHASE_ONLY))
        |=> $stable(running_phase_reg))
        else $error("waveshaper item changed the running phase");

    // A held item in the input stage is not lost while downstream is full.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s2_ready) |=> s1_valid_reg)
        else $error("input stage dropped a stalled item");

endmodule

// File: bench/wavetable_oscillator_interp_top_test.sv
`timescale 1ns / 1ps

module wavetable_oscillator_interp_top_test;

    // The bench runs the block at its default table size.
    localparam int TABLE_BITS  = wtoi_pkg::TABLE_BITS_DEFAULT;
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;

    // Field types of the two channels and the configuration port.
    typedef logic [wtoi_pkg::FUNC_W-1:0]         func_t;
    typedef logic signed [wtoi_pkg::FREQ_W-1:0]  freq_t;
    typedef logic [wtoi_pkg::PHASE_W-1:0]        phase_t;
    typedef logic [wtoi_pkg::ENTRY_INDEX_W-1:0]  index_t;
    typedef logic signed [wtoi_pkg::VALUE_W-1:0] value_t;
    typedef logic signed [wtoi_pkg::SLOPE_W-1:0] slope_t;
    typedef logic [wtoi_pkg::MODE_W-1:0]         mode_t;
    typedef logic [wtoi_pkg::INCR_SCALE_W-1:0]   scale_t;
    typedef logic [wtoi_pkg::CFG_INDEX_W-1:0]    cfg_index_t;
    typedef logic [wtoi_pkg::CFG_DATA_W-1:0]     cfg_data_t;

    // Codes that the package leaves unnamed because the block treats them as fallbacks.
    localparam func_t FUNC_UNUSED = 2'd3;
    localparam mode_t MODE_UNUSED = 2'd3;

    // The pipeline has four stages, so SETTLE_CYCLES cover any item still in flight.
    localparam int SETTLE_CYCLES   = 8;
    localparam int SINK_HOLD_CYCLES = 120;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int ITEMS_PER_SEGMENT = 15;
    localparam int NUM_SEGMENTS    = 6;
    localparam int MAX_REPORTS     = 10;

    // One predicted sample, kept with the phase it was read at for the report.
    typedef struct {
        value_t sample;
        phase_t read_phase;
    } sample_pred_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_we;
    cfg_index_t                  cfg_index;
    cfg_data_t                   cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    func_t                       s_func;
    freq_t                       s_freq_sample;
    phase_t                      s_phase_sample;
    index_t                      s_entry_index;
    value_t                      s_entry_value;
    slope_t                      s_entry_slope;
    logic                        m_valid;
    logic                        m_ready;
    value_t                      m_sample_out;

    // Shadow copy of the oscillator: its registers, phase accumulator and table.
    mode_t                       osc_mode;
    scale_t                      osc_incr_scale;
    phase_t                      osc_acc_phase;
    wtoi_pkg::entry_t            wave_mem [TABLE_DEPTH];

    // Samples the block still owes us, oldest first.
    sample_pred_t                pending_samples [$];

    int  error_count;
    int  cycle_count;
    bit  idle_on;
    bit  sink_hold;

    wavetable_oscillator_interp_top #(
        .TABLE_BITS     (TABLE_BITS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_freq_sample  (s_freq_sample),
        .s_phase_sample (s_phase_sample),
        .s_entry_index  (s_entry_index),
        .s_entry_value  (s_entry_value),
        .s_entry_slope  (s_entry_slope),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_out   (m_sample_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The watchdog counts clock cycles and stops a run that has hung.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Interpolated table read: value + floor(frac * slope / 2^16), clamped to 16 bits.
    function automatic value_t interp_lookup(input phase_t ph);
        wtoi_pkg::entry_t e;
        longint frac;
        longint acc;
        e    = wave_mem[ph[wtoi_pkg::PHASE_W-1 -: TABLE_BITS]];
        frac = longint'(ph[wtoi_pkg::PHASE_W-1-TABLE_BITS -: wtoi_pkg::FRAC_W]);
        acc  = longint'(e.value) + ((frac * longint'(e.slope)) >>> 16);
        if (acc > longint'(wtoi_pkg::SAMPLE_MAX))
            acc = longint'(wtoi_pkg::SAMPLE_MAX);
        if (acc < longint'(wtoi_pkg::SAMPLE_MIN))
            acc = longint'(wtoi_pkg::SAMPLE_MIN);
        return acc[wtoi_pkg::VALUE_W-1:0];
    endfunction

    // Advances the shadow oscillator by one accepted item and queues any sample it yields.
    task automatic advance_oscillator(
        input func_t  func,
        input freq_t  freq,
        input phase_t phase,
        input index_t idx,
        input value_t value,
        input slope_t slope
    );
        phase_t rd;
        longint step;
        sample_pred_t pred;
        case (func)
            wtoi_pkg::FUNC_LOAD: begin
                wave_mem[idx[TABLE_BITS-1:0]].value = value;
                wave_mem[idx[TABLE_BITS-1:0]].slope = slope;
            end
            wtoi_pkg::FUNC_SET_PHASE: begin
                osc_acc_phase = phase;
            end
            wtoi_pkg::FUNC_PROCESS: begin
                if (osc_mode == wtoi_pkg::MODE_PHASE_ONLY) begin
                    rd = phase;
                end else begin
                    // Mode 3 is not decoded, so it falls through to frequency only.
                    rd = osc_acc_phase;
                    if (osc_mode == wtoi_pkg::MODE_FREQ_PHASE)
                        rd = osc_acc_phase + phase;
                    step = (longint'(freq) * longint'(osc_incr_scale)) >>> 16;
                    osc_acc_phase = osc_acc_phase + step[wtoi_pkg::PHASE_W-1:0];
                end
                pred.sample     = interp_lookup(rd);
                pred.read_phase = rd;
                pending_samples.push_back(pred);
            end
            default: ;
        endcase
    endtask

    // Offers one item on the input channel and returns at the edge where it transfers.
    // Valid stays high on return, so back-to-back items do not drop it in between unless idling is on.
    task automatic send_item(
        input func_t  func,
        input freq_t  freq,
        input phase_t phase,
        input index_t idx,
        input value_t value,
        input slope_t slope
    );
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= func;
        s_freq_sample  <= freq;
        s_phase_sample <= phase;
        s_entry_index  <= idx;
        s_entry_value  <= value;
        s_entry_slope  <= slope;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        advance_oscillator(func, freq, phase, idx, value, slope);
    endtask

    task automatic send_process(input freq_t freq, input phase_t phase);
        send_item(wtoi_pkg::FUNC_PROCESS, freq, phase, index_t'($urandom()),
                  value_t'($urandom()), slope_t'($urandom()));
    endtask

    task automatic send_load(input index_t idx, input value_t value, input slope_t slope);
        send_item(wtoi_pkg::FUNC_LOAD, freq_t'($urandom()), $urandom(), idx, value, slope);
    endtask

    task automatic send_set_phase(input phase_t phase);
        send_item(wtoi_pkg::FUNC_SET_PHASE, freq_t'($urandom()), phase,
                  index_t'($urandom()), value_t'($urandom()), slope_t'($urandom()));
    endtask

    // Stops offering items and waits until every predicted sample has come out,
    // then lets the pipeline empty of items that carry no result.
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes one configuration register; the block must be idle.
    task automatic write_cfg(input cfg_index_t index, input cfg_data_t data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        case (index)
            wtoi_pkg::CFG_MODE:       osc_mode = data[wtoi_pkg::MODE_W-1:0];
            wtoi_pkg::CFG_INCR_SCALE: osc_incr_scale = data[wtoi_pkg::INCR_SCALE_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input mode_t mode, input scale_t scale);
        wait_for_idle();
        write_cfg(wtoi_pkg::CFG_MODE, cfg_data_t'(mode));
        write_cfg(wtoi_pkg::CFG_INCR_SCALE, cfg_data_t'(scale));
    endtask

    // Frequencies: the two extremes, audio-range tones of either sign, and anything.
    function automatic freq_t pick_freq();
        int tone;
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2, 3: begin
                tone = int'($urandom_range(0, 2 * (2000 << 8))) - (2000 << 8);
                return tone[wtoi_pkg::FREQ_W-1:0];
            end
            default: return freq_t'($urandom());
        endcase
    endfunction

    function automatic value_t pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return value_t'($urandom());
        endcase
    endfunction

    function automatic slope_t pick_slope();
        case ($urandom_range(0, 7))
            0: return 17'sh0FFFF;
            1: return 17'sh10000;
            default: return slope_t'($urandom());
        endcase
    endfunction

    // The sink accepts results at random, with stall bursts while idling is on.
    // When a long hold is requested it refuses everything for a fixed stretch,
    // which fills all four stages and forces the block to stall its input.
    initial begin : result_sink
        int stall;
        forever begin
            if (sink_hold) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                stall = $urandom_range(1, 9);
                repeat (stall) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Every result transfer is matched against the oldest predicted sample.
    always @(posedge aclk) begin : check_samples
        sample_pred_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: sample %0d arrived with none predicted",
                             $realtime, m_sample_out);
            end else begin
                want = pending_samples.pop_front();
                if (m_sample_out !== want.sample) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: sample_out at phase %h: expected %0d, got %0d",
                                 $realtime, want.read_phase, want.sample, m_sample_out);
                end
            end
        end
    end

    // Every table entry is loaded first, so no later read hits an unwritten entry.
    // Loading all addresses also walks every bit of the entry index.
    task automatic test_table_fill();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_load(index_t'(i), pick_value(), pick_slope());
    endtask

    // In the phase-only mode the read address is the item's own phase, which lets
    // us place the fraction exactly: full-scale slopes must clamp at both rails, and
    // a slope of -1 at the smallest fraction must round down to -1, not to zero.
    task automatic test_saturation_and_rounding();
        configure(wtoi_pkg::MODE_PHASE_ONLY, wtoi_pkg::INCR_SCALE_RESET);
        send_load(9'd5, 16'sh7FFF, 17'sh0FFFF);
        send_load(9'd6, 16'sh8000, 17'sh10000);
        send_load(9'd7, 16'sh0000, 17'sh1FFFF);
        send_load(9'd8, 16'sh0064, 17'sh0FFFF);
        send_process(freq_t'($urandom()), {9'd5, 16'hFFFF, 7'h7F});
        send_process(freq_t'($urandom()), {9'd5, 16'h0000, 7'h00});
        send_process(freq_t'($urandom()), {9'd6, 16'hFFFF, 7'h55});
        send_process(freq_t'($urandom()), {9'd7, 16'h0001, 7'h00});
        send_process(freq_t'($urandom()), {9'd8, 16'h8000, 7'h2A});
    endtask

    // The unused function code must pass through without a result or a side effect.
    task automatic test_ignored_function();
        send_item(FUNC_UNUSED, freq_t'($urandom()), $urandom(), 9'd5,
                  value_t'($urandom()), slope_t'($urandom()));
        send_process(freq_t'($urandom()), {9'd5, 16'hFFFF, 7'h00});
    endtask

    // Start just below a full turn and step with the largest positive frequency,
    // then with the most negative one, so the accumulator wraps both ways.
    task automatic test_phase_wrap();
        configure(wtoi_pkg::MODE_FREQ, 24'hFFFFFF);
        send_set_phase(32'hFFFF_FFF0);
        send_process(24'sh7FFFFF, $urandom());
        send_process(24'sh800000, $urandom());
        send_process(24'sh000000, $urandom());
        send_process(24'shFFFFFF, $urandom());
    endtask

    // The offset is added to the running phase only for the read, with wrap.
    task automatic test_phase_offset();
        configure(wtoi_pkg::MODE_FREQ_PHASE, scale_t'($urandom_range(0, 24'hFFFFFF)));
        send_set_phase($urandom());
        send_process(pick_freq(), 32'hFFFF_FFFF);
        send_process(pick_freq(), 32'h8000_0000);
        send_process(pick_freq(), $urandom());
    endtask

    // Mode 3 is not decoded and must behave as frequency only.
    task automatic test_unused_mode();
        configure(MODE_UNUSED, wtoi_pkg::INCR_SCALE_RESET);
        send_process(pick_freq(), $urandom());
        send_process(pick_freq(), $urandom());
        send_process(pick_freq(), $urandom());
    endtask

    // The sink holds off for a long stretch while we keep offering samples, so
    // the stages fill and s_ready must drop; nothing may be lost or duplicated.
    task automatic test_backpressure();
        configure(wtoi_pkg::MODE_FREQ, scale_t'($urandom_range(0, 24'hFFFFFF)));
        sink_hold = 1'b1;
        for (int i = 0; i < 40; i++)
            send_process(pick_freq(), $urandom());
    endtask

    // Random traffic in several register settings. Most items are samples, with
    // table rewrites and phase jumps mixed in; the unused code is noise that is
    // not counted. The third and the last segment run with no idling on either side.
    task automatic test_random_traffic();
        int counted;
        int pick;
        mode_t mode;
        scale_t scale;
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            case (seg)
                0: begin
                    mode  = wtoi_pkg::MODE_FREQ;
                    scale = scale_t'($urandom_range(0, 24'hFFFFFF));
                end
                1: begin
                    mode  = wtoi_pkg::MODE_FREQ_PHASE;
                    scale = 24'hFFFFFF;
                end
                2: begin
                    mode  = wtoi_pkg::MODE_PHASE_ONLY;
                    scale = 24'h000000;
                end
                3: begin
                    mode  = MODE_UNUSED;
                    scale = scale_t'($urandom_range(0, 24'hFFFFFF));
                end
                4: begin
                    mode  = wtoi_pkg::MODE_FREQ_PHASE;
                    scale = 24'h000000;
                end
                default: begin
                    mode  = wtoi_pkg::MODE_FREQ;
                    scale = wtoi_pkg::INCR_SCALE_RESET;
                end
            endcase
            configure(mode, scale);
            idle_on = (seg != 2) && (seg != NUM_SEGMENTS - 1);
            counted = 0;
            while (counted < ITEMS_PER_SEGMENT) begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    send_process(pick_freq(), $urandom());
                    counted++;
                end else if (pick < 84) begin
                    send_load(index_t'($urandom()), pick_value(), pick_slope());
                    counted++;
                end else if (pick < 93) begin
                    send_set_phase($urandom());
                    counted++;
                end else begin
                    send_item(FUNC_UNUSED, freq_t'($urandom()), $urandom(),
                              index_t'($urandom()), value_t'($urandom()),
                              slope_t'($urandom()));
                end
            end
        end
    endtask

    initial begin
        // Every input gets a known value before the first clock edge.
        aresetn        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= wtoi_pkg::CFG_MODE;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_func         <= wtoi_pkg::FUNC_PROCESS;
        s_freq_sample  <= '0;
        s_phase_sample <= '0;
        s_entry_index  <= '0;
        s_entry_value  <= '0;
        s_entry_slope  <= '0;
        error_count    = 0;
        idle_on        = 1'b1;
        sink_hold      = 1'b0;

        // The shadow state starts where reset leaves the block.
        osc_mode       = wtoi_pkg::MODE_RESET;
        osc_incr_scale = wtoi_pkg::INCR_SCALE_RESET;
        osc_acc_phase  = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_table_fill();
        test_saturation_and_rounding();
        test_ignored_function();
        test_phase_wrap();
        test_phase_offset();
        test_unused_mode();
        test_backpressure();
        test_random_traffic();

        // Drain what is left, then give a late or extra result time to show up.
        wait_for_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
